// ===== hw/rtl/tree_path_length_top_assert.svh =====
// assertion macros shared by the tree path length checker
`ifndef TREE_PATH_LENGTH_TOP_ASSERT_SVH
`define TREE_PATH_LENGTH_TOP_ASSERT_SVH

// condition in one cycle implies a consequence in the same cycle, idle in reset
`define TPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next cycle, idle in reset
`define TPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle check that also runs while reset is applied
`define TPL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpl_pkg.sv =====
// shared types and constants of the tree path length block
package tpl_pkg;

    localparam int NODE_W    = 10;
    localparam int LIMIT_W   = 11;
    localparam int EPOCH_W   = 8;
    localparam int MEM_DEPTH = 1 << NODE_W;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 10'd1023;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [NODE_W-1:0]  node;
        logic [NODE_W-1:0]  parent_node;
        logic [NODE_W-1:0]  target_node;
        logic [LIMIT_W-1:0] hop_limit;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0] path_nodes;
        logic              within_limit;
    } t_out;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR_ALL,
        OP_CLEAR_EPOCH,
        OP_CHECK,
        OP_MARK_START,
        OP_MARK_FIRST,
        OP_MARK_STEP,
        OP_CLIMB_START,
        OP_CLIMB_STEP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic trivial;
        logic wrap;
        logic parent_ok;
        logic mark_hit;
        logic climb_hit;
        logic step_limit;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/tpl_ctrl.sv =====
// controller state machine of the tree path length block
module tpl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_stall,
    input  tpl_pkg::t_status  i_status,
    output tpl_pkg::t_cmd     o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_CHECK  = 10'b00_0000_0100,
        S_WRAP   = 10'b00_0000_1000,
        S_MARK0  = 10'b00_0001_0000,
        S_MARK1  = 10'b00_0010_0000,
        S_MARK   = 10'b00_0100_0000,
        S_CLIMB0 = 10'b00_1000_0000,
        S_CLIMB  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = tpl_pkg::OP_NONE;
        o_cmd.take = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = tpl_pkg::OP_CLEAR_ALL;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_in_kind == tpl_pkg::KIND_QUERY) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.op = tpl_pkg::OP_CHECK;
                if (i_status.trivial) begin
                    n_state = S_DONE;
                end else if (i_status.wrap) begin
                    n_state = S_WRAP;
                end else begin
                    n_state = S_MARK0;
                end
            end
            S_WRAP: begin
                o_cmd.op = tpl_pkg::OP_CLEAR_EPOCH;
                if (i_status.sweep_last) begin
                    n_state = S_MARK0;
                end
            end
            S_MARK0: begin
                o_cmd.op = tpl_pkg::OP_MARK_START;
                n_state  = S_MARK1;
            end
            S_MARK1: begin
                o_cmd.op = tpl_pkg::OP_MARK_FIRST;
                n_state  = i_status.parent_ok ? S_MARK : S_CLIMB0;
            end
            S_MARK: begin
                o_cmd.op = tpl_pkg::OP_MARK_STEP;
                if (i_status.mark_hit || !i_status.parent_ok) begin
                    n_state = S_CLIMB0;
                end
            end
            S_CLIMB0: begin
                o_cmd.op = tpl_pkg::OP_CLIMB_START;
                n_state  = S_CLIMB;
            end
            S_CLIMB: begin
                o_cmd.op = tpl_pkg::OP_CLIMB_STEP;
                if (i_status.climb_hit || !i_status.parent_ok || i_status.step_limit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = tpl_pkg::OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tpl_dp.sv =====
// datapath of the tree path length block: tables, walk registers, result register
module tpl_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tpl_pkg::t_in                 i_in,
    input  tpl_pkg::t_cmd                i_cmd,
    output tpl_pkg::t_status             o_status,
    input  logic                         i_cfg_we,
    input  logic [tpl_pkg::NODE_W-1:0]   i_cfg_data,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output tpl_pkg::t_out                o_out
);

    // node is in use when nonzero and not above the configured count
    function automatic logic node_ok(input logic [tpl_pkg::NODE_W-1:0] v,
                                     input logic [tpl_pkg::NODE_W-1:0] cnt);
        return (v != '0) && (v <= cnt);
    endfunction

    // tables
    logic [tpl_pkg::NODE_W-1:0]  mem_parent [tpl_pkg::MEM_DEPTH];
    logic [tpl_pkg::EPOCH_W-1:0] mem_epoch  [tpl_pkg::MEM_DEPTH];
    logic [tpl_pkg::NODE_W-1:0]  mem_dist   [tpl_pkg::MEM_DEPTH];

    logic [tpl_pkg::NODE_W-1:0]  r_rd_parent;
    logic [tpl_pkg::EPOCH_W-1:0] r_rd_epoch;
    logic [tpl_pkg::NODE_W-1:0]  r_rd_dist;

    // control registers
    logic [tpl_pkg::NODE_W-1:0]  r_node_count;
    logic [tpl_pkg::NODE_W-1:0]  r_sweep;
    logic [tpl_pkg::EPOCH_W-1:0] r_qe;
    logic                        r_out_valid;

    // query and walk registers
    logic [tpl_pkg::NODE_W-1:0]  r_start;
    logic [tpl_pkg::NODE_W-1:0]  r_target;
    logic [tpl_pkg::LIMIT_W-1:0] r_limit;
    logic [tpl_pkg::NODE_W-1:0]  r_cur;
    logic [tpl_pkg::NODE_W-1:0]  r_dist;
    logic [tpl_pkg::NODE_W-1:0]  r_steps;
    logic                        r_self;
    logic [tpl_pkg::NODE_W-1:0]  r_count;
    tpl_pkg::t_out               r_out;

    logic q_bad;
    logic q_same;
    logic mark_hit;
    logic climb_hit;
    logic parent_ok;
    logic out_free;

    logic                        pt_we;
    logic [tpl_pkg::NODE_W-1:0]  pt_addr;
    logic [tpl_pkg::NODE_W-1:0]  pt_data;
    logic                        ep_we;
    logic [tpl_pkg::NODE_W-1:0]  ep_addr;
    logic [tpl_pkg::EPOCH_W-1:0] ep_data;
    logic                        ad_we;
    logic [tpl_pkg::NODE_W-1:0]  ad_addr;
    logic [tpl_pkg::NODE_W-1:0]  ad_data;
    logic [tpl_pkg::NODE_W-1:0]  rd_addr;

    // status toward the controller
    assign q_bad     = !node_ok(r_start, r_node_count) || !node_ok(r_target, r_node_count);
    assign q_same    = (r_start == r_target);
    assign parent_ok = node_ok(r_rd_parent, r_node_count);
    assign mark_hit  = (r_rd_epoch == r_qe) || r_self;
    assign climb_hit = (r_rd_epoch == r_qe);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_status.sweep_last = &r_sweep;
    assign o_status.trivial    = q_bad || q_same;
    assign o_status.wrap       = &r_qe;
    assign o_status.parent_ok  = parent_ok;
    assign o_status.mark_hit   = mark_hit;
    assign o_status.climb_hit  = climb_hit;
    assign o_status.step_limit = (r_steps == r_node_count);
    assign o_status.out_free   = out_free;

    // write and read port selection
    always_comb begin
        pt_we   = 1'b0;
        pt_addr = r_sweep;
        pt_data = '0;
        ep_we   = 1'b0;
        ep_addr = r_sweep;
        ep_data = '0;
        ad_we   = 1'b0;
        ad_addr = r_cur;
        ad_data = r_dist;
        rd_addr = r_rd_parent;
        if (i_cmd.take && (i_in.kind == tpl_pkg::KIND_LOAD) && (i_in.node != '0)) begin
            pt_we   = 1'b1;
            pt_addr = i_in.node;
            pt_data = i_in.parent_node;
        end
        case (i_cmd.op)
            tpl_pkg::OP_CLEAR_ALL: begin
                pt_we = 1'b1;
                ep_we = 1'b1;
            end
            tpl_pkg::OP_CLEAR_EPOCH: begin
                ep_we = 1'b1;
            end
            tpl_pkg::OP_MARK_START: begin
                ep_we   = 1'b1;
                ep_addr = r_start;
                ep_data = r_qe;
                ad_we   = 1'b1;
                ad_addr = r_start;
                ad_data = '0;
                rd_addr = r_start;
            end
            tpl_pkg::OP_MARK_STEP: begin
                ep_we   = !mark_hit;
                ep_addr = r_cur;
                ep_data = r_qe;
                ad_we   = !mark_hit;
            end
            tpl_pkg::OP_CLIMB_START: begin
                rd_addr = r_target;
            end
            default: begin
            end
        endcase
    end

    // parent table
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            mem_parent[pt_addr] <= pt_data;
        end
        r_rd_parent <= mem_parent[rd_addr];
    end

    // ancestor epoch marks
    always_ff @(posedge i_clk) begin
        if (ep_we) begin
            mem_epoch[ep_addr] <= ep_data;
        end
        r_rd_epoch <= mem_epoch[rd_addr];
    end

    // ancestor distances
    always_ff @(posedge i_clk) begin
        if (ad_we) begin
            mem_dist[ad_addr] <= ad_data;
        end
        r_rd_dist <= mem_dist[rd_addr];
    end

    // configuration, sweep counter, epoch and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= tpl_pkg::NODE_COUNT_RST;
            r_sweep      <= '0;
            r_qe         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if ((i_cmd.op == tpl_pkg::OP_CLEAR_ALL) || (i_cmd.op == tpl_pkg::OP_CLEAR_EPOCH)) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if ((i_cmd.op == tpl_pkg::OP_CHECK) && !(q_bad || q_same) && !(&r_qe)) begin
                r_qe <= r_qe + 1'b1;
            end else if ((i_cmd.op == tpl_pkg::OP_CLEAR_EPOCH) && (&r_sweep)) begin
                r_qe <= {{(tpl_pkg::EPOCH_W-1){1'b0}}, 1'b1};
            end
            if (i_cmd.op == tpl_pkg::OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query capture, walk registers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_start  <= i_in.node;
            r_target <= i_in.target_node;
            r_limit  <= i_in.hop_limit;
        end
        case (i_cmd.op)
            tpl_pkg::OP_CHECK: begin
                r_count <= {{(tpl_pkg::NODE_W-1){1'b0}}, (!q_bad && q_same)};
            end
            tpl_pkg::OP_MARK_FIRST: begin
                r_cur  <= r_rd_parent;
                r_dist <= {{(tpl_pkg::NODE_W-1){1'b0}}, 1'b1};
                r_self <= (r_rd_parent == r_start);
            end
            tpl_pkg::OP_MARK_STEP: begin
                r_cur  <= r_rd_parent;
                r_dist <= r_dist + 1'b1;
                r_self <= (r_rd_parent == r_cur);
            end
            tpl_pkg::OP_CLIMB_START: begin
                r_dist  <= '0;
                r_steps <= '0;
            end
            tpl_pkg::OP_CLIMB_STEP: begin
                if (climb_hit) begin
                    r_count <= r_rd_dist + r_dist + 1'b1;
                end else if (!parent_ok || (r_steps == r_node_count)) begin
                    r_count <= '0;
                end else begin
                    r_dist  <= r_dist + 1'b1;
                    r_steps <= r_steps + 1'b1;
                end
            end
            tpl_pkg::OP_FINISH: begin
                r_out.path_nodes   <= r_count;
                r_out.within_limit <= ({1'b0, r_count} <= r_limit);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/tree_path_length_top.sv =====
// top level of the tree path length block
//
//  channel  direction  handshake        payload
//  in       input      valid / stall    tpl_pkg::t_in  (load parent or path query)
//  out      output     valid / stall    tpl_pkg::t_out (one per query)
//  cfg      input      valid / ready    node_count, 10 bits, ready always high
//
// after reset a clearing pass over every table entry zeroes the parent and epoch tables;
// input stays stalled until it ends
// a load is written into the parent table as it is taken; a trivial query (bad node or start equal target)
// goes from the check straight to the result; a general query marks the start and its ancestors, then
// climbs from the target until it meets a marked node, runs out of parents or reaches the step limit
// the 256th marking query after reset, and every 255th after that, adds an
// epoch clear over the whole epoch table
// a stalled result sits in the output register while the next item is taken
module tree_path_length_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tpl_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tpl_pkg::t_out               o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tpl_pkg::NODE_W-1:0]  i_cfg_data
);

    tpl_pkg::t_cmd    cmd;
    tpl_pkg::t_status status;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    tpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in.kind),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tpl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== hw/rtl/tpl_checker.sv =====
// port-level checker for the tree path length block and its bind
`include "tree_path_length_top_assert.svh"

module tpl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input tpl_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input tpl_pkg::t_out o_out
);

    // a stalled result holds until its transfer
    `TPL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")

    // an unconnected pair is always within the limit
    `TPL_ASSERT_NOW(a_zero_within, i_clk, i_rst_n, o_out_valid && (o_out.path_nodes == '0), o_out.within_limit, "zero path not within limit")

    // a query transfer blocks the input while it is worked on
    `TPL_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in.kind == tpl_pkg::KIND_QUERY), o_in_stall, "input open right after a query")

    // the clearing pass after reset keeps the input stalled
    `TPL_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, o_in_stall, "input open during clearing pass")

endmodule

bind tree_path_length_top tpl_checker u_tpl_checker (.*);
